// ----- design/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// Used by the controller, the datapath and the top level; depends on nothing.
package lkvc_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_CAPACITY = '0;

  typedef struct packed {
    logic capture;
    logic lookup;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- design/lkvc_ctrl.sv -----
// Controller state machine of the LRU key-value cache.
// Sequences capture, lookup and commit of one transaction; uses lkvc_pkg.
module lkvc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lkvc_pkg::status_t status,
  output lkvc_pkg::cmd_t    cmd
);
  import lkvc_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_LOOKUP = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lkvc_datapath.sv -----
// Datapath of the LRU key-value cache: entry store, parallel key compare,
// recency ranks and the result register. Uses lkvc_pkg.
module lkvc_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  lkvc_pkg::cmd_t               cmd,
  output lkvc_pkg::status_t            status,
  input  logic [lkvc_pkg::CAP_W-1:0]   capacity,
  input  logic                         req_opcode,
  input  logic [lkvc_pkg::KEY_W-1:0]   req_key,
  input  logic [lkvc_pkg::VAL_W-1:0]   req_value,
  output logic                         res_valid,
  input  logic                         res_ready,
  output logic                         res_found,
  output logic [lkvc_pkg::VAL_W-1:0]   res_read_value,
  output logic                         res_evicted,
  output logic [lkvc_pkg::KEY_W-1:0]   res_evicted_key
);
  import lkvc_pkg::*;

  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic [KEY_W-1:0] entry_key   [ENTRIES];
  logic [VAL_W-1:0] entry_value [ENTRIES];
  logic [ENTRIES-1:0] entry_valid;
  logic [IDX_W-1:0] recency_rank [ENTRIES];
  logic [OCC_W-1:0] occupancy;

  logic             op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [IDX_W-1:0] hit_rank;
  logic             evict;
  logic             slot_ok;
  logic [IDX_W-1:0] slot_idx;

  logic             hit_c;
  logic [IDX_W-1:0] hit_idx_c;
  logic             lru_ok_c;
  logic [IDX_W-1:0] lru_idx_c;
  logic             free_ok_c;
  logic [IDX_W-1:0] free_idx_c;
  logic [CMP_W-1:0] eff_cap_c;
  logic             full_c;

  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    lru_ok_c   = 1'b0;
    lru_idx_c  = '0;
    free_ok_c  = 1'b0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == key) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!entry_valid[i]) begin
        free_ok_c  = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (entry_valid[i] && OCC_W'(recency_rank[i]) == occupancy - OCC_W'(1)) begin
        lru_ok_c  = 1'b1;
        lru_idx_c = IDX_W'(i);
      end
    end
    if (capacity == '0) begin
      eff_cap_c = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(ENTRIES)) begin
      eff_cap_c = CMP_W'(ENTRIES);
    end else begin
      eff_cap_c = CMP_W'(capacity);
    end
    full_c = (CMP_W'(occupancy) >= eff_cap_c) && (occupancy != '0) && lru_ok_c;
  end

  assign status.out_free = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op    <= req_opcode;
      key   <= req_key;
      value <= req_value;
    end
    if (cmd.lookup) begin
      hit      <= hit_c;
      hit_idx  <= hit_idx_c;
      hit_rank <= recency_rank[hit_idx_c];
      evict    <= full_c;
      slot_ok  <= full_c || free_ok_c;
      slot_idx <= full_c ? lru_idx_c : free_idx_c;
    end
    if (cmd.commit) begin
      res_found       <= hit;
      res_read_value  <= (hit && op == OP_GET) ? entry_value[hit_idx] : '0;
      res_evicted     <= !hit && op == OP_PUT && evict;
      res_evicted_key <= (!hit && op == OP_PUT && evict) ? entry_key[slot_idx] : '0;
      if (hit) begin
        if (op == OP_PUT) begin
          entry_value[hit_idx] <= value;
        end
      end else if (op == OP_PUT && slot_ok) begin
        entry_key[slot_idx]   <= key;
        entry_value[slot_idx] <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      occupancy   <= '0;
      res_valid   <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        recency_rank[i] <= '0;
      end
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (cmd.commit) begin
        res_valid <= 1'b1;
        if (hit) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i] && IDX_W'(i) != hit_idx && recency_rank[i] < hit_rank) begin
              recency_rank[i] <= recency_rank[i] + IDX_W'(1);
            end
          end
          recency_rank[hit_idx] <= '0;
        end else if (op == OP_PUT && slot_ok) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i]) begin
              recency_rank[i] <= recency_rank[i] + IDX_W'(1);
            end
          end
          recency_rank[slot_idx] <= '0;
          entry_valid[slot_idx]  <= 1'b1;
          if (!evict) begin
            occupancy <= occupancy + OCC_W'(1);
          end
        end
      end
    end
  end

endmodule

// ----- design/lru_key_value_cache.sv -----
// Top level of the LRU key-value cache: stream ports, APB capacity register
// and the controller and datapath instances. Uses lkvc_pkg, lkvc_ctrl, lkvc_datapath.
//
// Each get or put request yields one result. The request is first captured, then
// the parallel compare of all sixteen keys and the search for the least recent and
// the first free entry run, and last the entry and ranks are written back and the
// result register is loaded. A new request is taken only once the previous one has
// been written back, and a stalled result holds the write-back step. The capacity
// register sits at byte address 0, resets to 16, and should be written only while
// no request is in flight.
module lru_key_value_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // key [31:0], value [63:32]
  input  logic        s_tuser,  // opcode [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // read_value [31:0], evicted_key [63:32]
  output logic [1:0]  m_tuser,  // found [0], evicted [1]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lkvc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lkvc_pkg::*;

  logic [CAP_W-1:0] capacity;
  cmd_t             cmd;
  status_t          status;
  logic             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_ADDR_W-1:2] == ADDR_CAPACITY[CFG_ADDR_W-1:2];
  assign prdata  = cfg_sel ? {{(32 - CAP_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lkvc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .capacity        (capacity),
    .req_opcode      (s_tuser),
    .req_key         (s_tdata[31:0]),
    .req_value       (s_tdata[63:32]),
    .res_valid       (m_tvalid),
    .res_ready       (m_tready),
    .res_found       (m_tuser[0]),
    .res_read_value  (m_tdata[31:0]),
    .res_evicted     (m_tuser[1]),
    .res_evicted_key (m_tdata[63:32])
  );

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for lru_key_value_cache: drives get and put requests and
// capacity writes, checks every result against a built-in model of the LRU store
// or a directed row. Depends on lkvc_pkg and the lru_key_value_cache RTL.
module testbench;
  import lkvc_pkg::*;

  localparam int HOLD_CYCLES = 200;
  localparam int STALL_LIMIT = 2000;
  localparam int POOL_SIZE = 24;
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = CFG_ADDR_W'(4);

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] read_value;
    logic             evicted;
    logic [KEY_W-1:0] evicted_key;
  } access_res_t;

  typedef struct packed {
    logic             op;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic             typed;
    access_res_t      want;
  } stim_row_t;

  localparam access_res_t NO_HIT = '{1'b0, 32'h0, 1'b0, 32'h0};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  logic [KEY_W-1:0] line_key [ENTRIES];
  logic [VAL_W-1:0] line_value [ENTRIES];
  bit               line_valid [ENTRIES];
  int unsigned      line_rank [ENTRIES];
  int unsigned      line_count;
  logic [CAP_W-1:0] capacity_reg;

  access_res_t pending_results [$];
  stim_row_t   directed_rows [16];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int hits = 0;
  int evictions = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stall_cycles = 0;

  lru_key_value_cache uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Applies one request to the local copy of the store and returns its result.
  function automatic access_res_t cache_access(input logic op, input logic [KEY_W-1:0] key,
                                               input logic [VAL_W-1:0] value);
    access_res_t res = NO_HIT;
    int hit = -1;
    int slot = -1;
    int unsigned limit;
    for (int i = 0; i < ENTRIES; i++) begin
      if (line_valid[i] && line_key[i] == key) hit = i;
    end
    if (hit >= 0) begin
      res.found = 1'b1;
      if (op == OP_GET) res.read_value = line_value[hit];
      else line_value[hit] = value;
      for (int i = 0; i < ENTRIES; i++) begin
        if (line_valid[i] && i != hit && line_rank[i] < line_rank[hit]) line_rank[i]++;
      end
      line_rank[hit] = 0;
    end else if (op == OP_PUT) begin
      limit = 32'(capacity_reg);
      if (limit < 1) limit = 1;
      if (limit > ENTRIES) limit = ENTRIES;
      if (line_count >= limit && line_count > 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i] && line_rank[i] == line_count - 1) slot = i;
        end
        if (slot >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = line_key[slot];
          line_valid[slot] = 1'b0;
          line_count--;
        end
      end
      if (slot < 0) begin
        for (int i = ENTRIES - 1; i >= 0; i--) begin
          if (!line_valid[i]) slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (line_valid[i]) line_rank[i]++;
        end
        line_key[slot] = key;
        line_value[slot] = value;
        line_valid[slot] = 1'b1;
        line_rank[slot] = 0;
        line_count++;
      end
    end
    return res;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value, input logic typed,
                              input access_res_t want);
    access_res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {value, key};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    predicted = cache_access(op, key, value);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    if (predicted.found) hits++;
    if (predicted.evicted) evictions++;
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_CAPACITY) capacity_reg = data[CAP_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic cfg_check();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_CAPACITY;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    report_field("capacity readback", 32'(capacity_reg), prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data,
                           input int count, input int snd_pct, input int rcv_pct,
                           input int hold_at, input int pause_at);
    logic [KEY_W-1:0] pool [POOL_SIZE];
    logic [KEY_W-1:0] key;
    send_idle = snd_pct;
    recv_idle = rcv_pct;
    cfg_write(addr, data);
    cfg_check();
    pool[0] = 32'h0000_0000;
    pool[1] = 32'h8000_0000;
    pool[2] = 32'h7FFF_FFFF;
    pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) pool[i] = $urandom;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req++;
      if (n == pause_at) begin
        @(negedge clk);
        s_tvalid <= 1'b0;
        drain();
      end
      if ($urandom_range(99) < 85) key = pool[$urandom_range(POOL_SIZE - 1)];
      else key = $urandom;
      send_request(logic'($urandom_range(1)), key, $urandom, 1'b0, NO_HIT);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    drain();
  endtask

  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    access_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual tuser %b tdata %h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = pending_results.pop_front();
        report_field("found", 32'(want.found), 32'(m_tuser[0]));
        report_field("read_value", want.read_value, m_tdata[31:0]);
        report_field("evicted", 32'(want.evicted), 32'(m_tuser[1]));
        report_field("evicted_key", want.evicted_key, m_tdata[63:32]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("testbench failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_rank[i] = 0;
      line_key[i] = '0;
      line_value[i] = '0;
    end
    line_count = 0;
    capacity_reg = CAP_RESET;

    directed_rows = '{
      '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b1, NO_HIT},
      '{OP_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, NO_HIT},
      '{OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, NO_HIT},
      '{OP_GET, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h7FFF_FFFF, 1'b0, 32'h0}},
      '{OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, NO_HIT},
      '{OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NO_HIT},
      '{OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b0, 32'h0}},
      '{OP_PUT, 32'h8000_0000, 32'h0000_0000, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0, 1'b0, 32'h0}},
      '{OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, '{1'b1, 32'h8000_0000, 1'b0, 32'h0}},
      '{OP_PUT, 32'h0000_0000, 32'h1234_5678, 1'b1, NO_HIT},
      '{OP_GET, 32'h0000_0001, 32'hFFFF_FFFF, 1'b1, NO_HIT},
      '{OP_PUT, 32'h0000_0001, 32'hA5A5_A5A5, 1'b0, NO_HIT},
      '{OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, NO_HIT},
      '{OP_PUT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 1'b0, NO_HIT},
      '{OP_GET, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, NO_HIT}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle = 16;
    recv_idle = 55;
    cfg_check();
    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
                   directed_rows[i].typed, directed_rows[i].want);
    end
    @(negedge clk);
    s_tvalid <= 1'b0;
    drain();

    run_phase(ADDR_CAPACITY, 32'h0000_0000, 100, 16, 55, -1, -1);
    run_phase(ADDR_CAPACITY, 32'hFFFF_FFFF, 200, 16, 55, 20, -1);
    run_phase(ADDR_CAPACITY, 32'h0000_0002, 150, 55, 16, -1, -1);
    run_phase(ADDR_UNUSED, 32'h0000_0007, 100, 55, 16, -1, 60);
    run_phase(ADDR_CAPACITY, 32'h0000_0010, 250, 0, 0, -1, -1);
    run_phase(ADDR_CAPACITY, 32'h0000_0001, 100, 0, 0, -1, -1);

    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_results.size());
    end
    $display("Sent %0d requests and checked %0d results, with %0d hits and %0d evictions.",
             items_sent, results_checked, hits, evictions);
    $display("Capacities 16, 0, 31, 2 and 1 were used, plus a write to an unused address.");
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
